// ===== design/plhm_pkg.sv =====
package plhm_pkg;

  localparam logic [2:0] ST_FIRST    = 3'd0;
  localparam logic [2:0] ST_MEASURED = 3'd1;
  localparam logic [2:0] ST_GAP      = 3'd2;
  localparam logic [2:0] ST_REPEAT   = 3'd3;
  localparam logic [2:0] ST_ORDER    = 3'd4;
  localparam logic [2:0] ST_WRONG_ID = 3'd5;
  localparam logic [2:0] ST_READOUT  = 3'd6;

  localparam logic [0:0] MODE_READOUT = 1'b1;

  // x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
  localparam int          DIV_MAGIC_W = 29;
  localparam logic [28:0] DIV_MAGIC   = 29'd274877907;
  localparam int          DIV_SHIFT   = 38;
  localparam int          PROD_W      = 32 + DIV_MAGIC_W;
  localparam int          Q_W         = PROD_W - DIV_SHIFT;

  localparam int BIN_OFFSET = 10;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] latency;
    logic        new_max;
    logic        new_min;
    logic [31:0] gap;
    logic [31:0] bin_count;
    logic [31:0] total;
    logic [31:0] missed;
  } result_t;

endpackage

// ===== design/plhm_ram.sv =====
module plhm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/plhm_fifo.sv =====
module plhm_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  plhm_pkg::result_t push_data,
  input  logic              pop,
  output logic              not_empty,
  output plhm_pkg::result_t head
);

  plhm_pkg::result_t                     entries [plhm_pkg::FIFO_DEPTH];
  logic [plhm_pkg::FIFO_PTR_W-1:0]       wr_ptr;
  logic [plhm_pkg::FIFO_PTR_W-1:0]       rd_ptr;
  logic [plhm_pkg::FIFO_CNT_W-1:0]       count;
  logic [plhm_pkg::FIFO_CNT_W-1:0]       count_next;

  assign count_next = count + {{(plhm_pkg::FIFO_CNT_W-1){1'b0}}, push}
                            - {{(plhm_pkg::FIFO_CNT_W-1){1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

endmodule

// ===== design/packet_latency_histogram_monitor.sv =====
// A result passes through the stage registers s0 to s4 and into the output FIFO before out_valid shows it.
// Throughput: one transfer per cycle while in_stall is low; the bin update is one
// read-modify-write per item through a registered-read RAM with write-to-read forwarding.
// Reset (synchronous, active high) clears counters, state and valid flags, sets the expected
// id to 1, then sweeps the histogram RAM to zero, one bin per cycle, with in_stall high.
module packet_latency_histogram_monitor #(
  parameter int NUM_BINS = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [31:0]        stream_id,
  input  logic [31:0]        frame_number,
  input  logic [31:0]        tx_stamp,
  input  logic [31:0]        rx_stamp,
  input  logic [6:0]         bin_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] latency_us,
  output logic               new_max,
  output logic               new_min,
  output logic [31:0]        gap_count,
  output logic [31:0]        bin_count,
  output logic [31:0]        total_count,
  output logic [31:0]        missed_total
);

  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int Q_W   = plhm_pkg::Q_W;

  logic in_accept;
  logic out_pop;

  logic [31:0] expected_id;

  // clearing sweep
  logic             clr_active;
  logic [BIN_W-1:0] clr_addr;

  // transfers accepted but not yet taken
  logic [plhm_pkg::FIFO_CNT_W-1:0] pending;

  // stage 0: input register
  logic        s0_valid;
  logic        s0_mode;
  logic [31:0] s0_id;
  logic [31:0] s0_frame;
  logic [31:0] s0_tx;
  logic [31:0] s0_rx;
  logic [6:0]  s0_bin_index;

  // sequence state
  logic        started;
  logic [31:0] tx_base;
  logic [31:0] rx_base;
  logic [31:0] last_frame;
  logic [31:0] accepted_total;
  logic [31:0] missed_sum;
  logic [31:0] max_latency;
  logic [31:0] min_latency;

  logic        started_next;
  logic [31:0] tx_base_next;
  logic [31:0] rx_base_next;
  logic [31:0] last_frame_next;
  logic [31:0] accepted_total_next;
  logic [31:0] missed_sum_next;
  logic [31:0] max_latency_next;
  logic [31:0] min_latency_next;

  plhm_pkg::result_t c1_res;
  logic [31:0]       frame_diff;
  logic [31:0]       lat_raw;

  // stage 1
  logic              s1_valid;
  plhm_pkg::result_t s1_res;
  logic [6:0]        s1_bin_index;

  // stage 2
  logic              c2_new_max;
  logic              c2_new_min;
  plhm_pkg::result_t c2_res;
  logic              s2_valid;
  plhm_pkg::result_t s2_res;
  logic [6:0]        s2_bin_index;
  logic              s2_neg;
  logic [31:0]       s2_mag;

  // stage 3
  logic [plhm_pkg::PROD_W-1:0] prod;
  logic                        s3_valid;
  plhm_pkg::result_t           s3_res;
  logic [6:0]                  s3_bin_index;
  logic                        s3_neg;
  logic [Q_W-1:0]              s3_q;
  logic                        c3_inc;
  logic                        c3_rd_ok;
  logic [BIN_W-1:0]            c3_addr;

  // stage 4
  logic              s4_valid;
  plhm_pkg::result_t s4_res;
  logic              s4_inc;
  logic              s4_rd_ok;
  logic [BIN_W-1:0]  s4_addr;
  logic [31:0]       ram_rdata;
  logic [31:0]       bin_cur;
  plhm_pkg::result_t push_data;

  // last bin write, forwarded to the next read of the same bin
  logic             fwd_we;
  logic [BIN_W-1:0] fwd_addr;
  logic [31:0]      fwd_data;

  logic             ram_we;
  logic [BIN_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;

  plhm_pkg::result_t head;

  assign in_stall  = clr_active || (pending >= plhm_pkg::FIFO_CNT_W'(plhm_pkg::FIFO_DEPTH));
  assign in_accept = in_valid && !in_stall;
  assign out_pop   = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= 32'd1;
    end else if (cfg_wr_en) begin
      expected_id <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == BIN_W'(NUM_BINS - 1)) begin
        clr_active <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {{(plhm_pkg::FIFO_CNT_W-1){1'b0}}, in_accept}
                         - {{(plhm_pkg::FIFO_CNT_W-1){1'b0}}, out_pop};
    end
  end

  // stage 0
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s0_mode      <= mode;
      s0_id        <= stream_id;
      s0_frame     <= frame_number;
      s0_tx        <= tx_stamp;
      s0_rx        <= rx_stamp;
      s0_bin_index <= bin_index;
    end
  end

  // stage 1: classify by mode, stream id and the last frame, measure
  assign frame_diff = s0_frame - last_frame;
  assign lat_raw    = (s0_rx - rx_base) - (s0_tx - tx_base);

  always_comb begin
    started_next        = started;
    tx_base_next        = tx_base;
    rx_base_next        = rx_base;
    last_frame_next     = last_frame;
    accepted_total_next = accepted_total;
    missed_sum_next     = missed_sum;
    c1_res              = '0;
    if (s0_mode == plhm_pkg::MODE_READOUT) begin
      c1_res.status = plhm_pkg::ST_READOUT;
    end else if (s0_id != expected_id) begin
      c1_res.status = plhm_pkg::ST_WRONG_ID;
    end else if (!started) begin
      c1_res.status       = plhm_pkg::ST_FIRST;
      started_next        = 1'b1;
      tx_base_next        = s0_tx;
      rx_base_next        = s0_rx;
      last_frame_next     = s0_frame;
      accepted_total_next = accepted_total + 32'd1;
    end else begin
      if (s0_frame < last_frame) begin
        c1_res.status = plhm_pkg::ST_ORDER;
      end else if (s0_frame == last_frame) begin
        c1_res.status = plhm_pkg::ST_REPEAT;
      end else if (frame_diff != 32'd1) begin
        c1_res.status   = plhm_pkg::ST_GAP;
        c1_res.gap      = frame_diff - 32'd1;
        missed_sum_next = missed_sum + frame_diff - 32'd1;
      end else begin
        c1_res.status  = plhm_pkg::ST_MEASURED;
        c1_res.latency = lat_raw;
      end
      last_frame_next     = s0_frame;
      accepted_total_next = accepted_total + 32'd1;
    end
    c1_res.total  = accepted_total_next;
    c1_res.missed = missed_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started        <= 1'b0;
      tx_base        <= '0;
      rx_base        <= '0;
      last_frame     <= '0;
      accepted_total <= '0;
      missed_sum     <= '0;
      s1_valid       <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
      if (s0_valid) begin
        started        <= started_next;
        tx_base        <= tx_base_next;
        rx_base        <= rx_base_next;
        last_frame     <= last_frame_next;
        accepted_total <= accepted_total_next;
        missed_sum     <= missed_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_res       <= c1_res;
    s1_bin_index <= s0_bin_index;
  end

  // stage 2: running extremes, magnitude
  always_comb begin
    c2_new_max       = 1'b0;
    c2_new_min       = 1'b0;
    max_latency_next = max_latency;
    min_latency_next = min_latency;
    if (s1_valid && s1_res.status == plhm_pkg::ST_MEASURED) begin
      if ($signed(s1_res.latency) > $signed(max_latency)) begin
        c2_new_max       = 1'b1;
        max_latency_next = s1_res.latency;
      end
      if ($signed(s1_res.latency) < $signed(min_latency)) begin
        c2_new_min       = 1'b1;
        min_latency_next = s1_res.latency;
      end
    end
  end

  always_comb begin
    c2_res         = s1_res;
    c2_res.new_max = c2_new_max;
    c2_res.new_min = c2_new_min;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_latency <= '0;
      min_latency <= '0;
      s2_valid    <= 1'b0;
    end else begin
      max_latency <= max_latency_next;
      min_latency <= min_latency_next;
      s2_valid    <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_res       <= c2_res;
    s2_bin_index <= s1_bin_index;
    s2_neg       <= s1_res.latency[31];
    s2_mag       <= s1_res.latency[31] ? (~s1_res.latency + 32'd1) : s1_res.latency;
  end

  // stage 3: whole milliseconds by reciprocal multiply
  assign prod = plhm_pkg::PROD_W'(s2_mag) * plhm_pkg::PROD_W'(plhm_pkg::DIV_MAGIC);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_res       <= s2_res;
    s3_bin_index <= s2_bin_index;
    s3_neg       <= s2_neg;
    s3_q         <= prod[plhm_pkg::PROD_W-1:plhm_pkg::DIV_SHIFT];
  end

  // bin select, RAM read issue
  always_comb begin
    c3_inc   = 1'b0;
    c3_rd_ok = 1'b0;
    if (s3_neg) begin
      c3_addr = BIN_W'(plhm_pkg::BIN_OFFSET) - BIN_W'(s3_q);
    end else begin
      c3_addr = BIN_W'(plhm_pkg::BIN_OFFSET) + BIN_W'(s3_q);
    end
    if (s3_res.status == plhm_pkg::ST_READOUT) begin
      c3_addr  = BIN_W'(s3_bin_index);
      c3_rd_ok = ({25'd0, s3_bin_index} < 32'(NUM_BINS));
    end else if (s3_res.status == plhm_pkg::ST_MEASURED) begin
      if (s3_neg) begin
        c3_inc = (s3_q <= Q_W'(plhm_pkg::BIN_OFFSET));
      end else begin
        c3_inc = (s3_q < Q_W'(NUM_BINS - plhm_pkg::BIN_OFFSET));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_res   <= s3_res;
    s4_inc   <= c3_inc;
    s4_rd_ok <= c3_rd_ok;
    s4_addr  <= c3_addr;
  end

  // stage 4: read-modify-write of one bin, or a clearing write during the sweep
  assign bin_cur = (fwd_we && fwd_addr == s4_addr) ? fwd_data : ram_rdata;

  always_comb begin
    if (clr_active) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s4_valid && s4_inc;
      ram_waddr = s4_addr;
      ram_wdata = bin_cur + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_we <= 1'b0;
    end else begin
      fwd_we <= ram_we && !clr_active;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= ram_waddr;
    fwd_data <= ram_wdata;
  end

  plhm_ram #(
    .WIDTH(32),
    .DEPTH(NUM_BINS)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(c3_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    push_data           = s4_res;
    push_data.bin_count = s4_rd_ok ? bin_cur : 32'd0;
  end

  plhm_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (s4_valid),
    .push_data(push_data),
    .pop      (out_pop),
    .not_empty(out_valid),
    .head     (head)
  );

  assign status       = head.status;
  assign latency_us   = $signed(head.latency);
  assign new_max      = head.new_max;
  assign new_min      = head.new_min;
  assign gap_count    = head.gap;
  assign bin_count    = head.bin_count;
  assign total_count  = head.total;
  assign missed_total = head.missed;

`ifndef SYNTHESIS
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= plhm_pkg::FIFO_CNT_W'(plhm_pkg::FIFO_DEPTH))
    else $error("pending transfers exceed output buffer");

  a_empty_pending: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> (32'(pending) ==
      32'($countones({s0_valid, s1_valid, s2_valid, s3_valid, s4_valid}))))
    else $error("pending count out of step with pipeline");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !(s0_valid || s1_valid || s2_valid || s3_valid || s4_valid))
    else $error("item in flight during bin clear");

  a_extremes_order: assert property (@(posedge clk) disable iff (rst)
    $signed(max_latency) >= $signed(min_latency))
    else $error("running max below running min");

  a_extreme_flags: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> !(s2_res.new_max && s2_res.new_min))
    else $error("new max and new min flagged together");
`endif

endmodule
